/* rtl/pkdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkdr_pkg: shared definitions for the payload keyword drop and rewrite block
// Register defaults, register indexes, verdict codes, control structs and the
// pattern byte selector used by the top level and its cells.
// ----------------------------------------------------------------------------
package pkdr_pkg;

	// Configuration register layout
	localparam int unsigned REG_W = 32;
	localparam int unsigned REG_BYTES = REG_W / 8;
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DROP   = 2'd0,
		REG_MATCH  = 2'd1,
		REG_CHANGE = 2'd2
	} cfg_reg_t;

	// Reset values of the pattern registers ("eeff", "aabb", "ccdd")
	localparam logic [REG_W-1:0] DROP_RESET   = 32'h6565_6666;
	localparam logic [REG_W-1:0] MATCH_RESET  = 32'h6161_6262;
	localparam logic [REG_W-1:0] CHANGE_RESET = 32'h6363_6464;

	// Default keyword length in bytes
	localparam int unsigned PATTERN_BYTES_DEF = 4;

	// Verdict carried on the last byte of a packet
	typedef enum logic [1:0] {
		VERDICT_PASS    = 2'd0,
		VERDICT_DROP    = 2'd1,
		VERDICT_REWRITE = 2'd2
	} verdict_t;

	// Control handed to every window cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Control handed to the output buffer
	typedef struct packed {
		logic     load;
		logic     last;
		verdict_t verdict;
	} obuf_ctrl_t;

	// Byte j of a pattern, counted from the newest (least significant) end;
	// bytes beyond the register read as zero
	function automatic logic [7:0] pat_byte(input logic [REG_W-1:0] w, input int unsigned j);
		logic [7:0] r;
		r = 8'h00;
		if (j < REG_BYTES) begin
			r = w[8*j +: 8];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/pkdr_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkdr stream interfaces
// Valid/ready channels for payload bytes in and rewritten bytes out.
// ----------------------------------------------------------------------------
interface pkdr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       packet_end;

	modport source(output valid, output data_byte, output packet_end, input ready);
	modport sink(input valid, input data_byte, input packet_end, output ready);
endinterface

interface pkdr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic [1:0] verdict;

	modport source(output valid, output out_byte, output out_last, output verdict,
		input ready);
	modport sink(input valid, input out_byte, input out_last, input verdict,
		output ready);
endinterface
`default_nettype wire

/* rtl/pkdr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkdr_cell: one byte position of the search windows
// Holds one original byte and one rewritten byte, shifts them on to the next
// cell on each transfer inside a packet, and compares its original and
// rewritten byte with its position of the drop and match patterns.
// ----------------------------------------------------------------------------
module pkdr_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire pkdr_pkg::cell_ctrl_t ctrl,
	input  wire [7:0]           in_orig,
	input  wire [7:0]           in_rew,
	input  wire                 in_valid,
	input  wire [7:0]           drop_byte,
	input  wire [7:0]           match_byte,
	output logic [7:0]          orig,
	output logic [7:0]          rew,
	output logic                valid,
	output logic                drop_eq,
	output logic                match_eq
);

	logic [7:0] orig_q;
	logic [7:0] rew_q;
	logic       valid_q;

	// Occupancy: drop at packet end, take the neighbour's flag on a shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= in_valid;
		end
	end

	// Window bytes: advance on each transfer inside a packet
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			orig_q <= in_orig;
			rew_q  <= in_rew;
		end
	end

	assign orig     = orig_q;
	assign rew      = rew_q;
	assign valid    = valid_q;
	assign drop_eq  = (orig_q == drop_byte);
	assign match_eq = (rew_q == match_byte);

endmodule
`default_nettype wire

/* rtl/pkdr_obuf.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pkdr_obuf: output register stage
// Holds one emitted byte, or the whole window at packet end, and presents the
// bytes oldest first; marks the final byte with the packet verdict.
// ----------------------------------------------------------------------------
module pkdr_obuf #(
	parameter int unsigned PATTERN_BYTES = pkdr_pkg::PATTERN_BYTES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire pkdr_pkg::obuf_ctrl_t    ctrl,
	input  wire [$clog2(PATTERN_BYTES+1)-1:0] load_cnt,
	input  wire [7:0]                    load_bytes [PATTERN_BYTES],
	output logic                         can_load,
	pkdr_out_if.source                   result
);

	localparam int unsigned CW   = $clog2(PATTERN_BYTES + 1);
	localparam int unsigned IDXW = (PATTERN_BYTES > 1) ? $clog2(PATTERN_BYTES) : 1;

	logic [7:0]         bytes_q [PATTERN_BYTES];
	logic [CW-1:0]      cnt_q;
	logic               last_q;
	pkdr_pkg::verdict_t verdict_q;
	logic               pop;
	logic [CW-1:0]      cnt_m1;
	logic               final_byte;

	assign pop      = (cnt_q != '0) && result.ready;
	assign can_load = (cnt_q == '0) || ((cnt_q == CW'(1)) && result.ready);
	assign cnt_m1   = cnt_q - CW'(1);

	// Count of bytes still to send: reload on a new batch, count down per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctrl.load) begin
			cnt_q <= load_cnt;
		end else if (pop) begin
			cnt_q <= cnt_m1;
		end
	end

	// Batch payload: hold until the next load
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bytes_q   <= load_bytes;
			last_q    <= ctrl.last;
			verdict_q <= ctrl.verdict;
		end
	end

	assign final_byte      = last_q && (cnt_q == CW'(1));
	assign result.valid    = (cnt_q != '0);
	assign result.out_byte = bytes_q[cnt_m1[IDXW-1:0]];
	assign result.out_last = final_byte;
	assign result.verdict  = final_byte ? verdict_q : pkdr_pkg::VERDICT_PASS;

endmodule
`default_nettype wire

/* rtl/payload_keyword_drop_and_rewrite.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// payload_keyword_drop_and_rewrite: packet payload keyword filter and rewriter
// A chain of window cells tracks the last PATTERN_BYTES-1 original and
// rewritten bytes; the drop keyword marks the packet for discard and each
// match word is replaced by the change word, scanned left to right.
// ----------------------------------------------------------------------------
// Throughput: one payload byte per cycle inside a packet, unless the output stalls.
// Latency: a byte leaves PATTERN_BYTES-1 bytes after it arrives, through one
//   output register; a packet shorter than that leaves only at its end.
// Packet end: the window (up to PATTERN_BYTES bytes) drains from the output
//   register one byte a cycle while ready is high; input waits for its last byte.
// Reset: clears the windows, packet flags and output stage, and loads the
//   pattern registers with their defaults.
module payload_keyword_drop_and_rewrite #(
	parameter int unsigned PATTERN_BYTES = pkdr_pkg::PATTERN_BYTES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [pkdr_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire [pkdr_pkg::REG_W-1:0]        cfg_data,
	pkdr_in_if.sink                          payload,
	pkdr_out_if.source                       result
);

	localparam int unsigned NC = (PATTERN_BYTES > 1) ? PATTERN_BYTES - 1 : 1;
	localparam int unsigned CW = $clog2(PATTERN_BYTES + 1);

	logic [pkdr_pkg::REG_W-1:0] drop_pattern_q;
	logic [pkdr_pkg::REG_W-1:0] match_pattern_q;
	logic [pkdr_pkg::REG_W-1:0] change_pattern_q;
	logic                       drop_seen_q;
	logic                       rewrite_seen_q;

	logic [7:0]  c_orig [NC];
	logic [7:0]  c_rew  [NC];
	logic [NC-1:0] c_valid;
	logic [NC-1:0] c_deq;
	logic [NC-1:0] c_meq;

	logic [7:0]  cand_raw [PATTERN_BYTES];
	logic [7:0]  cand_fin [PATTERN_BYTES];
	logic [7:0]  load_bytes [PATTERN_BYTES];

	pkdr_pkg::cell_ctrl_t cctrl;
	pkdr_pkg::obuf_ctrl_t octrl;
	logic          accept;
	logic          can_load;
	logic          full;
	logic          win_deq;
	logic          win_meq;
	logic          drop_hit;
	logic          replace;
	logic [CW-1:0] fill;
	logic [CW-1:0] k_cnt;
	logic [CW-1:0] load_cnt;

	assign payload.ready = can_load;
	assign accept        = payload.valid && can_load;
	assign cctrl.shift   = accept && !payload.packet_end;
	assign cctrl.clear   = accept && payload.packet_end;

	// Pattern registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_pattern_q   <= pkdr_pkg::DROP_RESET;
			match_pattern_q  <= pkdr_pkg::MATCH_RESET;
			change_pattern_q <= pkdr_pkg::CHANGE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				pkdr_pkg::REG_DROP:   drop_pattern_q   <= cfg_data;
				pkdr_pkg::REG_MATCH:  match_pattern_q  <= cfg_data;
				pkdr_pkg::REG_CHANGE: change_pattern_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Chain of window cells; cell j holds candidate byte j and compares as byte j+1
	generate
		if (PATTERN_BYTES > 1) begin : g_chain
			for (genvar j = 0; j < PATTERN_BYTES - 1; j++) begin : g_cell
				pkdr_cell u_cell (
					.clk        (clk),
					.arst_n     (arst_n),
					.ctrl       (cctrl),
					.in_orig    ((j == 0) ? payload.data_byte : c_orig[(j == 0) ? 0 : j-1]),
					.in_rew     (cand_fin[j]),
					.in_valid   ((j == 0) ? 1'b1 : c_valid[(j == 0) ? 0 : j-1]),
					.drop_byte  (pkdr_pkg::pat_byte(drop_pattern_q, j + 1)),
					.match_byte (pkdr_pkg::pat_byte(match_pattern_q, j + 1)),
					.orig       (c_orig[j]),
					.rew        (c_rew[j]),
					.valid      (c_valid[j]),
					.drop_eq    (c_deq[j]),
					.match_eq   (c_meq[j])
				);
			end
			assign full    = c_valid[NC-1];
			assign win_deq = &c_deq;
			assign win_meq = &c_meq;
		end else begin : g_nochain
			assign c_orig[0] = 8'h00;
			assign c_rew[0]  = 8'h00;
			assign c_valid   = '0;
			assign c_deq     = '0;
			assign c_meq     = '0;
			assign full      = 1'b1;
			assign win_deq   = 1'b1;
			assign win_meq   = 1'b1;
		end
	endgenerate

	// Match on the full window, newest byte included
	assign drop_hit = full && win_deq
		&& (payload.data_byte == pkdr_pkg::pat_byte(drop_pattern_q, 0));
	assign replace  = full && win_meq
		&& (payload.data_byte == pkdr_pkg::pat_byte(match_pattern_q, 0));

	// Candidate word, with the change word written over a match
	generate
		for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cand
			if (j == 0) begin : g_new
				assign cand_raw[j] = payload.data_byte;
			end else begin : g_old
				assign cand_raw[j] = c_rew[j-1];
			end
			assign cand_fin[j] = replace ? pkdr_pkg::pat_byte(change_pattern_q, j)
				: cand_raw[j];
		end
	endgenerate

	// Window occupancy: valid cells form a prefix of the chain
	always_comb begin
		fill = '0;
		for (int unsigned j = 0; j < PATTERN_BYTES - 1; j++) begin
			fill = fill + CW'(c_valid[j]);
		end
	end
	assign k_cnt = fill + CW'(1);

	// Output batch: the oldest byte alone, or the whole window at packet end
	always_comb begin
		for (int unsigned j = 0; j < PATTERN_BYTES; j++) begin
			load_bytes[j] = cand_fin[j];
		end
		if (!payload.packet_end) begin
			load_bytes[0] = cand_fin[PATTERN_BYTES-1];
		end
	end
	assign load_cnt = payload.packet_end ? k_cnt : CW'(1);

	assign octrl.load    = accept && (payload.packet_end || full);
	assign octrl.last    = payload.packet_end;
	assign octrl.verdict = (drop_seen_q || drop_hit) ? pkdr_pkg::VERDICT_DROP
		: ((rewrite_seen_q || replace) ? pkdr_pkg::VERDICT_REWRITE
		: pkdr_pkg::VERDICT_PASS);

	// Packet flags: gather hits, drop at packet end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_seen_q    <= 1'b0;
			rewrite_seen_q <= 1'b0;
		end else if (cctrl.clear) begin
			drop_seen_q    <= 1'b0;
			rewrite_seen_q <= 1'b0;
		end else if (cctrl.shift) begin
			drop_seen_q    <= drop_seen_q || drop_hit;
			rewrite_seen_q <= rewrite_seen_q || replace;
		end
	end

	pkdr_obuf #(
		.PATTERN_BYTES (PATTERN_BYTES)
	) u_obuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (octrl),
		.load_cnt   (load_cnt),
		.load_bytes (load_bytes),
		.can_load   (can_load),
		.result     (result)
	);

endmodule
`default_nettype wire
